// ===== sv/cgi_pkg.sv =====
package cgi_pkg;

  // Marks are kept in rows of this many channels.
  localparam int ROW_BITS = 32;
  localparam int BIT_W    = 5;

  localparam logic [1:0] MODE_STORE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] ST_MEASURED = 3'd0;
  localparam logic [2:0] ST_INTERP   = 3'd1;
  localparam logic [2:0] ST_EXTRAP   = 3'd2;
  localparam logic [2:0] ST_UNCAL    = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_ACK      = 3'd5;

  localparam logic REG_CHANNEL_BASE = 1'b0;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_SRD, S_SWR, S_CHK, S_CHKE,
    S_LISS, S_LEVAL, S_RISS, S_REVAL, S_PICK,
    S_G1, S_G1W, S_G2, S_G2W, S_MUL, S_DIV, S_DIVW, S_SUM, S_DONE
  } state_t;

  // Index of the lowest set bit.
  function automatic logic [BIT_W-1:0] lsb32(input logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Index of the highest set bit.
  function automatic logic [BIT_W-1:0] msb32(input logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== sv/cgi_div.sv =====
module cgi_div #(
  parameter int NW = 31,
  parameter int DW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [DW-1:0] dmag;
  logic [DW-1:0] rem;
  logic [NW-1:0] nq;
  logic [DW:0]   sh;
  logic          take;

  // One restoring step per cycle on magnitudes; the sign is applied at the end.
  assign sh   = {rem, nq[NW-1]};
  assign take = sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        neg     <= num[NW-1] ^ den[DW-1];
        nq      <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag    <= den[DW-1] ? DW'(-den) : DW'(den);
        rem     <= '0;
      end else if (running) begin
        rem <= take ? DW'(sh - {1'b0, dmag}) : DW'(sh);
        nq  <= {nq[NW-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(nq) : $signed(nq);

endmodule

// ===== sv/calibration_gap_interpolator_core.sv =====
// Gain calibration table with gap interpolation.
//
// An item is given on mode, port, column, freq_mhz and gain_in together with
// start, and it is taken at a clock edge where start is high and busy is low.
// Exactly one result follows for each item: gain_out and status are valid
// for the single cycle in which done is high, and the receiver must take it
// then, because the block has no way to hold it.
// A store item reads, modifies and writes a mark row. A clear item zeroes
// the port's mark rows one per cycle, ROWS being CHANNELS / 32 rounded up.
// A read of a measured channel reads its mark row and then its gain. Other
// reads walk the mark rows down and up from the channel, then run a signed
// divider that retires one quotient bit per cycle. Items are handled one at
// a time; busy stays high until the result has been shown.
// After reset the block first clears every mark row, holding busy high; the
// channel_base register resets to zero and can be written over the APB port
// at any time.
module calibration_gap_interpolator_core #(
  parameter int CHANNELS = 1024,
  parameter int PORTS    = 8,
  parameter int COLUMNS  = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [2:0]         port,
  input  logic [3:0]         column,
  input  logic [15:0]        freq_mhz,
  input  logic signed [15:0] gain_in,
  output logic               done,
  output logic signed [15:0] gain_out,
  output logic [2:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cgi_pkg::*;

  localparam int ROWS = (CHANNELS + ROW_BITS - 1) / ROW_BITS;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW   = RAW + BIT_W;
  localparam int MD   = PORTS * ROWS;
  localparam int MAW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int GD   = PORTS * COLUMNS * CHANNELS;
  localparam int GAW  = $clog2(GD);
  localparam int PCN  = PORTS * COLUMNS;
  localparam int PCW  = (PCN > 1) ? $clog2(PCN) : 1;
  localparam int NW   = 17 + PW + 1;
  localparam int DW   = PW + 1;

  state_t state, state_next;

  // Configuration register.
  logic [15:0] channel_base;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANNEL_BASE) ? {16'd0, channel_base} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_base <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_BASE) begin
      channel_base <= pwdata[15:0];
    end
  end

  // Memories: mark rows and the gain table.
  logic [ROW_BITS-1:0] mmem [MD];
  logic [15:0]         gmem [GD];

  logic [MAW-1:0]      maddr;
  logic                mwe;
  logic [ROW_BITS-1:0] mwdata;
  logic [ROW_BITS-1:0] mrow_q;
  logic [GAW-1:0]      gaddr;
  logic                gwe;
  logic [15:0]         gdata_q;
  logic [PW-1:0]       gx;

  // Item registers.
  logic [1:0]         mode_q;
  logic [2:0]         port_q;
  logic [PCW-1:0]     pc_q;
  logic [PW-1:0]      ch_q;
  logic signed [15:0] gin_q;
  logic [MAW-1:0]     cnt;
  logic [RAW-1:0]     scan_row;
  logic [PW-1:0]      lb;
  logic               has_l, has_r, has_r2;
  logic [PW-1:0]      l_pos, r_pos, r2_pos;
  logic [PW-1:0]      x1, x2;
  logic               two_pts;
  logic signed [15:0] y1, y2;
  logic [2:0]         kind;
  logic signed [NW-1:0] prod;
  logic signed [DW-1:0] den;
  logic signed [15:0] gain_res;
  logic [2:0]         status_res;

  logic                 div_start;
  logic                 div_done;
  logic signed [NW-1:0] quo;

  always_ff @(posedge clk) begin
    if (mwe) mmem[maddr] <= mwdata;
    mrow_q <= mmem[maddr];
  end

  always_ff @(posedge clk) begin
    if (gwe) gmem[gaddr] <= gin_q;
    gdata_q <= gmem[gaddr];
  end

  assign gaddr = GAW'(32'(pc_q) * CHANNELS + 32'(gx));

  // Range check of an incoming item.
  logic [16:0] diff;
  logic        port_ok, col_ok, ch_ok, item_ok;

  assign diff    = {1'b0, freq_mhz} - {1'b0, channel_base};
  assign port_ok = 32'(port) < PORTS;
  assign col_ok  = 32'(column) < COLUMNS;
  assign ch_ok   = !diff[16] && (32'(diff[15:0]) < CHANNELS);
  assign item_ok = port_ok && col_ok && ch_ok &&
                   (mode == MODE_STORE || mode == MODE_READ);

  // Row search helpers.
  logic [RAW-1:0]      ch_row, lb_row;
  logic [BIT_W-1:0]    ch_bit, lb_bit;
  logic [ROW_BITS-1:0] lmasked, rmasked;
  logic [PW-1:0]       lfound, rfound;

  assign ch_row  = ch_q[PW-1:BIT_W];
  assign ch_bit  = ch_q[BIT_W-1:0];
  assign lb_row  = lb[PW-1:BIT_W];
  assign lb_bit  = lb[BIT_W-1:0];
  assign lmasked = mrow_q & ((scan_row == ch_row) ?
                   ((32'd1 << ch_bit) - 32'd1) : '1);
  assign rmasked = mrow_q & ((scan_row == lb_row) ?
                   ~((32'd2 << lb_bit) - 32'd1) : '1);
  assign lfound  = {scan_row, msb32(lmasked)};
  assign rfound  = {scan_row, lsb32(rmasked)};

  logic signed [NW:0] sum;
  assign sum = NW'(y1) + (NW+1)'(quo);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  if (cnt == MAW'(MD - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_CLEAR && port_ok) state_next = S_CLR;
          else if (!item_ok)                 state_next = S_DONE;
          else if (mode == MODE_STORE)       state_next = S_SRD;
          else                               state_next = S_CHK;
        end
      end
      S_CLR:   if (cnt == MAW'(ROWS - 1)) state_next = S_DONE;
      S_SRD:   state_next = S_SWR;
      S_SWR:   state_next = S_DONE;
      S_CHK:   state_next = S_CHKE;
      S_CHKE:  state_next = mrow_q[ch_bit] ? S_G1 : S_LEVAL;
      S_LISS:  state_next = S_LEVAL;
      S_LEVAL: begin
        if (lmasked != '0 || scan_row == '0) state_next = S_RISS;
        else                                 state_next = S_LISS;
      end
      S_RISS:  state_next = S_REVAL;
      S_REVAL: begin
        if (rmasked != '0) begin
          if (has_r || has_l) state_next = S_PICK;
          else                state_next = S_REVAL;
        end else if (scan_row == RAW'(ROWS - 1)) begin
          state_next = S_PICK;
        end else begin
          state_next = S_RISS;
        end
      end
      S_PICK:  state_next = has_r ? S_G1 : S_DONE;
      S_G1:    state_next = S_G1W;
      S_G1W:   state_next = (kind == ST_MEASURED) ? S_DONE :
                            (two_pts ? S_G2 : S_MUL);
      S_G2:    state_next = S_G2W;
      S_G2W:   state_next = S_MUL;
      S_MUL:   state_next = S_DIV;
      S_DIV:   state_next = S_DIVW;
      S_DIVW:  if (div_done) state_next = S_SUM;
      S_SUM:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    busy      = (state != S_IDLE);
    done      = (state == S_DONE);
    div_start = (state == S_DIV);
    mwe       = 1'b0;
    mwdata    = '0;
    gwe       = 1'b0;
    gx        = x1;
    maddr     = MAW'(32'(port_q) * ROWS + 32'(scan_row));
    unique case (state)
      S_INIT: begin
        mwe   = 1'b1;
        maddr = cnt;
      end
      S_CLR: begin
        mwe   = 1'b1;
        maddr = MAW'(32'(port_q) * ROWS + 32'(cnt));
      end
      S_SWR: begin
        mwe    = 1'b1;
        mwdata = mrow_q | (32'd1 << ch_bit);
        gwe    = 1'b1;
        gx     = ch_q;
      end
      S_G2:    gx = x2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_INIT, S_CLR: cnt <= cnt + 1'b1;
        S_IDLE: begin
          cnt        <= '0;
          mode_q     <= mode;
          port_q     <= port;
          pc_q       <= PCW'(32'(port) * COLUMNS + 32'(column));
          ch_q       <= PW'(diff[15:0]);
          lb         <= PW'(diff[15:0]);
          scan_row   <= RAW'(diff[15:BIT_W]);
          gin_q      <= gain_in;
          has_l      <= 1'b0;
          has_r      <= 1'b0;
          has_r2     <= 1'b0;
          gain_res   <= '0;
          status_res <= (mode == MODE_CLEAR && port_ok) ? ST_ACK : ST_RANGE;
        end
        S_SWR: status_res <= ST_ACK;
        S_CHKE: begin
          x1   <= ch_q;
          kind <= ST_MEASURED;
        end
        S_LEVAL: begin
          if (lmasked != '0) begin
            has_l    <= 1'b1;
            l_pos    <= lfound;
            scan_row <= ch_row;
          end else if (scan_row == '0) begin
            scan_row <= ch_row;
          end else begin
            scan_row <= scan_row - 1'b1;
          end
        end
        S_REVAL: begin
          if (rmasked != '0) begin
            if (!has_r) begin
              has_r <= 1'b1;
              r_pos <= rfound;
              lb    <= rfound;
            end else begin
              has_r2 <= 1'b1;
              r2_pos <= rfound;
            end
          end else if (scan_row != RAW'(ROWS - 1)) begin
            scan_row <= scan_row + 1'b1;
          end
        end
        S_PICK: begin
          two_pts <= 1'b1;
          y2      <= '0;
          if (has_l && has_r) begin
            x1   <= l_pos;
            x2   <= r_pos;
            kind <= ST_INTERP;
          end else if (has_r2) begin
            x1   <= r_pos;
            x2   <= r2_pos;
            kind <= ST_EXTRAP;
          end else begin
            x1      <= r_pos;
            x2      <= '0;
            two_pts <= 1'b0;
            kind    <= ST_EXTRAP;
          end
          status_res <= ST_UNCAL;
          gain_res   <= '0;
        end
        S_G1W: begin
          y1 <= gdata_q;
          if (kind == ST_MEASURED) begin
            gain_res   <= gdata_q;
            status_res <= ST_MEASURED;
          end
        end
        S_G2W: y2 <= gdata_q;
        S_MUL: begin
          prod <= NW'(17'(y2) - 17'(y1)) *
                  NW'($signed({1'b0, ch_q}) - $signed({1'b0, x1}));
          den  <= $signed({1'b0, x2}) - $signed({1'b0, x1});
        end
        S_SUM: begin
          status_res <= kind;
          if (sum > (NW+1)'(32767))       gain_res <= 16'sd32767;
          else if (sum < -(NW+1)'(32768)) gain_res <= -16'sd32768;
          else                            gain_res <= sum[15:0];
        end
        default: ;
      endcase
    end
  end

  cgi_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  assign gain_out = gain_res;
  assign status   = status_res;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block not free after result");
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not start work");
  a_ack: assert property (@(posedge clk) disable iff (rst)
                          (done && mode_q != MODE_READ && status != ST_RANGE)
                          |-> status == ST_ACK)
    else $error("store or clear without acknowledge");

endmodule

// ===== tb/calibration_gap_interpolator_core_tb.sv =====
module calibration_gap_interpolator_core_tb;
  import cgi_pkg::*;

  // Table sizes of the block as instantiated with its default parameters.
  localparam int NCHAN = 1024;
  localparam int NPORT = 8;
  localparam int NCOL  = 12;

  // One item as offered to the block, together with the result that the
  // gain table predictor expects once the block has taken it.
  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         port;
    logic [3:0]         column;
    logic [15:0]        freq;
    logic signed [15:0] gain;
    logic signed [15:0] exp_gain;
    logic [2:0]         exp_status;
  } cal_item_t;

  typedef struct {
    logic signed [15:0] gain;
    logic [2:0]         status;
  } cal_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode = '0;
  logic [2:0]         port = '0;
  logic [3:0]         column = '0;
  logic [15:0]        freq_mhz = '0;
  logic signed [15:0] gain_in = '0;
  logic               done;
  logic signed [15:0] gain_out;
  logic [2:0]         status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  calibration_gap_interpolator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .port(port), .column(column), .freq_mhz(freq_mhz),
    .gain_in(gain_in), .done(done), .gain_out(gain_out), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the gain table, the measured marks and the register.
  // gain_written tracks which gains hold a real value, so that no read is
  // ever generated that would pick up a never-written gain.
  logic signed [15:0] gain_table [NPORT][NCOL][NCHAN];
  bit                 gain_written [NPORT][NCOL][NCHAN];
  bit                 marked [NPORT][NCHAN];
  int unsigned        chan_base;

  cal_item_t   pending_items[$];
  cal_result_t awaited_results[$];
  cal_item_t   cur_item;
  int          idle_pct;
  int          mismatches;

  initial begin
    forever #4 clk = ~clk;
  end

  // Straight line through (x1,y1) and (x2,y2) evaluated at x. The product
  // is formed first and the quotient truncates toward zero; the sum then
  // saturates to the 16-bit gain range.
  function automatic logic signed [15:0] line_gain(input longint x1, input longint y1,
                                                    input longint x2, input longint y2,
                                                    input longint x);
    longint y;
    if (x2 == x1) return y1[15:0];
    y = y1 + ((y2 - y1) * (x - x1)) / (x2 - x1);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  // Works out the result of one item and applies its effect on the shadow
  // table. Returns 0, leaving everything untouched, when a read would need
  // a gain that was never written; such reads are never sent.
  function automatic bit predict_gain(inout cal_item_t it);
    int  ch;
    int  l;
    int  r;
    int  r2;
    bit  has_l;
    bit  has_r;
    bit  has_r2;
    it.exp_gain   = '0;
    it.exp_status = ST_RANGE;
    if (it.mode == MODE_CLEAR) begin
      if (it.port < NPORT) begin
        for (int j = 0; j < NCHAN; j++) marked[it.port][j] = 1'b0;
        it.exp_status = ST_ACK;
      end
      return 1'b1;
    end
    if ((it.mode != MODE_STORE && it.mode != MODE_READ) || it.port >= NPORT ||
        it.column >= NCOL || it.freq < chan_base)
      return 1'b1;
    ch = int'(it.freq) - int'(chan_base);
    if (ch >= NCHAN) return 1'b1;

    if (it.mode == MODE_STORE) begin
      gain_table[it.port][it.column][ch]   = it.gain;
      gain_written[it.port][it.column][ch] = 1'b1;
      marked[it.port][ch] = 1'b1;
      it.exp_status = ST_ACK;
      return 1'b1;
    end

    if (marked[it.port][ch]) begin
      if (!gain_written[it.port][it.column][ch]) return 1'b0;
      it.exp_gain   = gain_table[it.port][it.column][ch];
      it.exp_status = ST_MEASURED;
      return 1'b1;
    end

    // Nearest mark below, then the first one or two marks above.
    has_l = 0; has_r = 0; has_r2 = 0; l = 0; r = 0; r2 = 0;
    for (int j = ch - 1; j >= 0; j--) begin
      if (marked[it.port][j]) begin
        has_l = 1; l = j;
        break;
      end
    end
    for (int j = ch + 1; j < NCHAN; j++) begin
      if (marked[it.port][j]) begin
        if (!has_r) begin
          has_r = 1; r = j;
          if (has_l) break;
        end else begin
          has_r2 = 1; r2 = j;
          break;
        end
      end
    end

    if (has_l && has_r) begin
      if (!gain_written[it.port][it.column][l] || !gain_written[it.port][it.column][r])
        return 1'b0;
      it.exp_gain = line_gain(l, gain_table[it.port][it.column][l],
                              r, gain_table[it.port][it.column][r], ch);
      it.exp_status = ST_INTERP;
    end else if (has_r && has_r2) begin
      if (!gain_written[it.port][it.column][r] || !gain_written[it.port][it.column][r2])
        return 1'b0;
      it.exp_gain = line_gain(r, gain_table[it.port][it.column][r],
                              r2, gain_table[it.port][it.column][r2], ch);
      it.exp_status = ST_EXTRAP;
    end else if (has_r) begin
      // A single mark: the line runs down to zero at channel 0.
      if (!gain_written[it.port][it.column][r]) return 1'b0;
      it.exp_gain = line_gain(r, gain_table[it.port][it.column][r], 0, 0, ch);
      it.exp_status = ST_EXTRAP;
    end else begin
      it.exp_status = ST_UNCAL;
    end
    return 1'b1;
  endfunction

  // Driver. An item is taken at an edge where start is high and busy is
  // low; its expectation is queued right then. start is given one value per
  // edge, so back-to-back items keep it high without a glitch.
  always @(posedge clk) begin
    bit taken;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken)
        awaited_results.push_back('{gain: cur_item.exp_gain, status: cur_item.exp_status});
      if (!start || taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = pending_items.pop_front();
          mode     <= cur_item.mode;
          port     <= cur_item.port;
          column   <= cur_item.column;
          freq_mhz <= cur_item.freq;
          gain_in  <= cur_item.gain;
          start    <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result lasts for one cycle only and is compared with the
  // oldest expectation when done is seen at the edge.
  always @(posedge clk) begin
    cal_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: gain_out %0d status %0d", gain_out, status);
      end else begin
        want = awaited_results.pop_front();
        if (gain_out !== want.gain || status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected gain %0d status %0d, got gain %0d status %0d",
                     want.gain, want.status, gain_out, status);
        end
      end
    end
  end

  // Writes channel_base over the register port: a setup cycle, then an
  // access cycle that commits at the following edge.
  task automatic write_channel_base(input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_CHANNEL_BASE);
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    chan_base = value;
  endtask

  // Queues one item after predicting its result.
  task automatic queue_item(input logic [1:0] m, input logic [2:0] p, input logic [3:0] k,
                            input logic [15:0] f, input logic signed [15:0] g);
    cal_item_t it;
    it = '{mode: m, port: p, column: k, freq: f, gain: g, exp_gain: '0, exp_status: '0};
    void'(predict_gain(it));
    pending_items.push_back(it);
  endtask

  // Returns once every queued item has been taken and answered.
  task automatic wait_drained();
    while (pending_items.size() > 0 || start || awaited_results.size() > 0 || busy)
      @(posedge clk);
  endtask

  // Random items for one register setting. Most traffic sits in a small
  // channel window on a few columns so that interpolation and extrapolation
  // over real marks dominate; the rest hits the range limits and odd modes.
  task automatic queue_random(input int count);
    cal_item_t it;
    int        pick;
    int        off;
    bit        ok;
    for (int n = 0; n < count; n++) begin
      ok = 0;
      for (int tries = 0; tries < 30 && !ok; tries++) begin
        pick = $urandom_range(99);
        if (pick < 40)      it.mode = MODE_STORE;
        else if (pick < 92) it.mode = MODE_READ;
        else if (pick < 97) it.mode = MODE_CLEAR;
        else                it.mode = 2'd3;
        it.port   = $urandom_range(7);
        it.column = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 80)      off = $urandom_range(47);
        else if (pick < 88) off = $urandom_range(NCHAN - 1);
        else if (pick < 92) off = NCHAN - 1;
        else if (pick < 95) off = NCHAN + $urandom_range(7);
        else                off = -1;
        it.freq = (off < 0) ? 16'($urandom) : 16'(chan_base + off);
        pick = $urandom_range(99);
        if (pick < 70)      it.gain = 16'($urandom);
        else if (pick < 78) it.gain = 16'sh7fff;
        else if (pick < 85) it.gain = -16'sh8000;
        else                it.gain = 16'($urandom_range(511)) - 16'sd256;
        ok = predict_gain(it);
      end
      if (!ok) begin
        it.mode = MODE_STORE;
        void'(predict_gain(it));
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    logic [15:0] bases [5];
    bases = '{16'd65535, 16'd30000, 16'd64512, 16'd0, 16'd777};
    idle_pct   = 17;
    mismatches = 0;
    chan_base  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed items at channel_base zero: a measured read, a gap, the
    // one-mark line from zero, the two-mark extrapolation, a channel above
    // the last mark, saturation, range errors, the unknown mode and a clear.
    write_channel_base(16'd0);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd10,   16'sd0);
    queue_item(MODE_STORE, 3'd0, 4'd0,  16'd10,   16'sd100);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd10,   16'sd0);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd5,    16'sd0);
    queue_item(MODE_STORE, 3'd0, 4'd0,  16'd20,   -16'sh8000);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd15,   16'sd0);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd3,    16'sd0);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd0,    16'sd0);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd30,   16'sd0);
    queue_item(MODE_STORE, 3'd1, 4'd11, 16'd100,  16'sh7fff);
    queue_item(MODE_STORE, 3'd1, 4'd11, 16'd101,  -16'sh8000);
    queue_item(MODE_READ,  3'd1, 4'd11, 16'd0,    16'sd0);
    queue_item(MODE_READ,  3'd1, 4'd11, 16'd1023, 16'sd0);
    queue_item(MODE_STORE, 3'd7, 4'd5,  16'd1023, -16'sd1);
    queue_item(MODE_READ,  3'd7, 4'd5,  16'd1023, 16'sd0);
    queue_item(MODE_READ,  3'd7, 4'd5,  16'd512,  16'sd0);
    queue_item(MODE_READ,  3'd7, 4'd15, 16'd10,   16'sd0);
    queue_item(MODE_STORE, 3'd7, 4'd12, 16'd10,   16'sd7);
    queue_item(MODE_READ,  3'd7, 4'd5,  16'd1024, 16'sd0);
    queue_item(MODE_STORE, 3'd7, 4'd5,  16'hffff, 16'sd7);
    queue_item(2'd3,       3'd7, 4'd5,  16'd10,   16'sd7);
    queue_item(MODE_READ,  3'd4, 4'd0,  16'd10,   16'sd0);
    queue_item(MODE_CLEAR, 3'd0, 4'd0,  16'd0,    16'sd0);
    queue_item(MODE_READ,  3'd0, 4'd0,  16'd10,   16'sd0);
    queue_random(200);
    wait_drained();

    // Further register settings, the extremes among them. The third one
    // runs with no idle cycles at all.
    for (int ph = 0; ph < 5; ph++) begin
      write_channel_base(bases[ph]);
      idle_pct = (ph == 2) ? 0 : 17;
      queue_random(230);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
